// ----- src/rmsmip_pkg.sv -----
// Shared constants and types for the RMS 2x2 mipmap downsampler.
package rmsmip_pkg;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam int CFG_WIDTH_W  = 12;
    localparam int CFG_HEIGHT_W = 13;
    localparam int CFG_DATA_W   = 13;

    localparam int BYTE_W  = 8;
    localparam int SQ_W    = 16;
    localparam int CH_W    = 17;
    localparam int QUAD_W  = 18;
    localparam int STORE_W = 3 * CH_W;
    localparam int NUM_CH  = 3;

    localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hFF;

    localparam logic REG_SRC_WIDTH  = 1'b0;
    localparam logic REG_SRC_HEIGHT = 1'b1;

    typedef logic [CH_W-1:0]   t_ch_sum;
    typedef logic [SQ_W-1:0]   t_mean;
    typedef logic [BYTE_W-1:0] t_byte;

endpackage

// ----- src/rms_2x2_mipmap_downsample_top.sv -----
// Top level of the RMS 2x2 mipmap downsampler: sequencer, counters and output register.
// Every pixel is squared; an odd column of an even row stores its pair sums, and an odd column
// of an odd row adds them to the stored pair and takes the root. No new pixel is taken until
// the last is done; one shared 8x8 multiplier does the three squares and all 24 root trial
// steps. A result enters the output register and waits there while the next pixels are taken.
// Synchronous active-low reset clears counters and sequencer; width and height reset to 2048.
module rms_2x2_mipmap_downsample_top import rmsmip_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [31:0]           i_pixel_in,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [31:0]           o_out_color,
    output logic                  o_end_of_row,
    output logic                  o_end_of_image
);

    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int CNW   = $clog2(MAX_WIDTH);
    localparam int RNW   = $clog2(MAX_HEIGHT);
    localparam int DEPTH = MAX_WIDTH / 2;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW    = (WW > CFG_WIDTH_W) ? WW : CFG_WIDTH_W;
    localparam int XH    = (HW > CFG_HEIGHT_W) ? HW : CFG_HEIGHT_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQ   = 3'd1;
    localparam logic [2:0] S_SUM  = 3'd2;
    localparam logic [2:0] S_ROOT = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [CFG_WIDTH_W-1:0]  r_src_width;
    logic [CFG_HEIGHT_W-1:0] r_src_height;
    logic [2:0]              r_state;
    logic [CNW-1:0]          r_col, n_col;
    logic [RNW-1:0]          r_row, n_row;
    logic [1:0]              r_ch;
    logic [2:0]              r_bit;
    logic [BYTE_W-1:0]       r_root;
    logic                    r_valid;

    logic [23:0]             r_pix;
    logic                    r_col_odd;
    logic                    r_row_odd;
    logic [AW-1:0]           r_idx;
    logic                    r_idx_ok;
    logic                    r_eor_p;
    logic                    r_eoi_p;
    t_ch_sum                 r_pend [NUM_CH];
    t_ch_sum                 r_pair [NUM_CH];
    t_mean                   r_acc  [NUM_CH];
    t_byte                   r_res  [NUM_CH];
    logic [31:0]             r_out_color;
    logic                    r_out_eor;
    logic                    r_out_eoi;

    logic [XW-1:0]           w_ext;
    logic [XH-1:0]           h_ext;
    logic [WW-1:0]           w_eff;
    logic [HW-1:0]           h_eff;
    logic                    in_acc;
    logic                    out_load;
    logic [CNW-1:0]          half_col;
    logic                    idx_ok;
    logic                    eor;
    logic                    eoi;
    t_byte                   sq_operand;
    t_byte                   trial;
    t_byte                   root_next;
    logic [SQ_W-1:0]         product;
    logic                    le;
    logic                    st_we;
    logic                    st_re;
    logic [STORE_W-1:0]      st_wdata;
    logic [STORE_W-1:0]      st_rdata;
    t_ch_sum                 top_sum [NUM_CH];

    assign w_ext = XW'(r_src_width);
    assign h_ext = XH'(r_src_height);

    always_comb begin
        if (w_ext < XW'(2)) begin
            w_eff = WW'(2);
        end else if (w_ext > XW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(w_ext);
        end
        if (h_ext < XH'(2)) begin
            h_eff = HW'(2);
        end else if (h_ext > XH'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(h_ext);
        end
    end

    assign o_stall  = (r_state != S_IDLE);
    assign in_acc   = i_valid && !o_stall;
    assign out_load = (r_state == S_OUT) && (!r_valid || !i_stall);

    assign half_col = r_col >> 1;
    assign idx_ok   = (half_col < CNW'(DEPTH));
    assign eor      = (WW'(half_col) == (w_eff >> 1) - WW'(1));
    assign eoi      = eor && (HW'(r_row >> 1) == (h_eff >> 1) - HW'(1));

    always_comb begin
        n_col = r_col + CNW'(1);
        n_row = r_row;
        if (WW'(r_col) + WW'(1) >= w_eff) begin
            n_col = '0;
            if (HW'(r_row) + HW'(1) >= h_eff) begin
                n_row = '0;
            end else begin
                n_row = r_row + RNW'(1);
            end
        end
    end

    always_comb begin
        case (r_ch)
            2'd0:    sq_operand = r_pix[23:16];
            2'd1:    sq_operand = r_pix[15:8];
            default: sq_operand = r_pix[7:0];
        endcase
    end

    assign trial     = r_root | (BYTE_W'(1) << r_bit);
    assign root_next = le ? trial : r_root;

    rmsmip_sq_unit u_sq (
        .i_operand (r_state == S_SQ ? sq_operand : trial),
        .i_limit   (r_acc[r_ch]),
        .o_product (product),
        .o_le      (le)
    );

    assign st_we    = (r_state == S_SUM) && !r_row_odd && r_idx_ok;
    assign st_re    = in_acc && r_col[0] && r_row[0] && idx_ok;
    assign st_wdata = {r_pair[0], r_pair[1], r_pair[2]};

    rmsmip_line_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (r_idx),
        .i_wdata (st_wdata),
        .i_re    (st_re),
        .i_raddr (AW'(half_col)),
        .o_rdata (st_rdata)
    );

    assign top_sum[0] = st_rdata[3*CH_W-1:2*CH_W];
    assign top_sum[1] = st_rdata[2*CH_W-1:CH_W];
    assign top_sum[2] = st_rdata[CH_W-1:0];

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= CFG_WIDTH_W'(2048);
            r_src_height <= CFG_HEIGHT_W'(2048);
            r_state      <= S_IDLE;
            r_col        <= '0;
            r_row        <= '0;
            r_ch         <= '0;
            r_bit        <= '0;
            r_root       <= '0;
            r_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_SRC_WIDTH:  r_src_width  <= i_cfg_data[CFG_WIDTH_W-1:0];
                    REG_SRC_HEIGHT: r_src_height <= i_cfg_data[CFG_HEIGHT_W-1:0];
                    default: ;
                endcase
            end

            if (out_load) begin
                r_valid <= 1'b1;
            end else if (r_valid && !i_stall) begin
                r_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_col   <= n_col;
                        r_row   <= n_row;
                        r_ch    <= '0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (r_ch == 2'd2) begin
                        r_ch    <= '0;
                        r_state <= r_col_odd ? S_SUM : S_IDLE;
                    end else begin
                        r_ch <= r_ch + 2'd1;
                    end
                end
                S_SUM: begin
                    r_ch    <= '0;
                    r_bit   <= 3'd7;
                    r_root  <= '0;
                    r_state <= r_row_odd ? S_ROOT : S_IDLE;
                end
                S_ROOT: begin
                    if (r_bit == 3'd0) begin
                        r_root <= '0;
                        r_bit  <= 3'd7;
                        if (r_ch == 2'd2) begin
                            r_ch    <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_ch <= r_ch + 2'd1;
                        end
                    end else begin
                        r_root <= root_next;
                        r_bit  <= r_bit - 3'd1;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pix     <= i_pixel_in[23:0];
            r_col_odd <= r_col[0];
            r_row_odd <= r_row[0];
            r_idx     <= AW'(half_col);
            r_idx_ok  <= idx_ok;
            r_eor_p   <= eor;
            r_eoi_p   <= eoi;
        end
        if (r_state == S_SQ) begin
            if (r_col_odd) begin
                r_pair[r_ch] <= r_pend[r_ch] + CH_W'(product);
            end else begin
                r_pend[r_ch] <= CH_W'(product);
            end
        end
        if (r_state == S_SUM) begin
            for (int k = 0; k < NUM_CH; k++) begin
                r_acc[k] <= SQ_W'((QUAD_W'(top_sum[k]) + QUAD_W'(r_pair[k])) >> 2);
            end
        end
        if (r_state == S_ROOT && r_bit == 3'd0) begin
            r_res[r_ch] <= root_next;
        end
        if (out_load) begin
            r_out_color <= {ALPHA_OPAQUE, r_res[0], r_res[1], r_res[2]};
            r_out_eor   <= r_eor_p;
            r_out_eoi   <= r_eoi_p;
        end
    end

    assign o_valid        = r_valid;
    assign o_out_color    = r_out_color;
    assign o_end_of_row   = r_out_eor;
    assign o_end_of_image = r_out_eoi;

endmodule

// ----- src/rmsmip_sq_unit.sv -----
// Shared 8x8 squaring multiplier with a less-or-equal compare against a limit.
module rmsmip_sq_unit import rmsmip_pkg::*; (
    input  t_byte             i_operand,
    input  t_mean             i_limit,
    output logic [SQ_W-1:0]   o_product,
    output logic              o_le
);

    assign o_product = SQ_W'(i_operand) * SQ_W'(i_operand);
    assign o_le      = (o_product <= i_limit);

endmodule

// ----- src/rmsmip_line_store.sv -----
// Half-row store of per-channel pair sums of squares, registered read.
module rmsmip_line_store import rmsmip_pkg::*; #(
    parameter int DEPTH = DEF_MAX_WIDTH / 2,
    parameter int AW    = 10
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  logic [STORE_W-1:0] i_wdata,
    input  logic               i_re,
    input  logic [AW-1:0]      i_raddr,
    output logic [STORE_W-1:0] o_rdata
);

    logic [STORE_W-1:0] r_mem [DEPTH];
    logic [STORE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- test/rms_2x2_mipmap_downsample_top_tb.sv -----
// Testbench for the RMS 2x2 mipmap downsampler: random pixel streams checked against a predictor.
`timescale 1ns / 100ps

module rms_2x2_mipmap_downsample_top_tb;
    import rmsmip_pkg::*;

    localparam int unsigned MAX_W       = DEF_MAX_WIDTH;
    localparam int unsigned MAX_H       = DEF_MAX_HEIGHT;
    localparam int unsigned DRAIN_WAIT  = 40;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned RANDOM_PIX  = 300;
    localparam int unsigned WIDE_PIX    = 40;
    localparam int unsigned HOLD_PIX    = 64;
    localparam int unsigned STEADY_PIX  = 128;

    typedef struct packed {
        logic [31:0] color;
        logic        eor;
        logic        eoi;
    } t_mip_px;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic                  i_cfg_idx  = REG_SRC_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid    = 1'b0;
    logic                  o_stall;
    logic [31:0]           i_pixel_in = '0;
    logic                  o_valid;
    logic                  i_stall    = 1'b0;
    logic [31:0]           o_out_color;
    logic                  o_end_of_row;
    logic                  o_end_of_image;

    logic [31:0] src_pixels_q [$];
    t_mip_px     mip_px_q     [$];

    logic [CFG_WIDTH_W-1:0]  src_w_q = CFG_WIDTH_W'(2048);
    logic [CFG_HEIGHT_W-1:0] src_h_q = CFG_HEIGHT_W'(2048);
    int unsigned             col_pos = 0;
    int unsigned             row_pos = 0;
    t_ch_sum                 left_sq     [NUM_CH] = '{default: '0};
    t_ch_sum                 pair_sq_mem [DEF_MAX_WIDTH/2][NUM_CH];

    bit          gaps_on   = 1'b1;
    bit          hold_req  = 1'b0;
    bit          hold_done = 1'b0;
    int unsigned hold_left = 0;
    int unsigned quiet_cycles = 0;
    int unsigned mismatches = 0;

    rms_2x2_mipmap_downsample_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_pixel_in     (i_pixel_in),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_color    (o_out_color),
        .o_end_of_row   (o_end_of_row),
        .o_end_of_image (o_end_of_image)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
        if (v < 2) return 2;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic t_byte int_root(input int unsigned v);
        t_byte       r;
        int unsigned trial;
        r = '0;
        for (int b = BYTE_W - 1; b >= 0; b--) begin
            trial = r | (1 << b);
            if (trial * trial <= v) r = trial[BYTE_W-1:0];
        end
        return r;
    endfunction

    function automatic bit downsample_pixel(input logic [31:0] px, output t_mip_px res);
        int unsigned w, h, idx;
        t_ch_sum     sq   [NUM_CH];
        t_ch_sum     pair [NUM_CH];
        t_byte       root [NUM_CH];
        bit          has;
        w   = clamp_dim(src_w_q, MAX_W);
        h   = clamp_dim(src_h_q, MAX_H);
        idx = col_pos >> 1;
        has = 1'b0;
        res = '0;
        for (int c = 0; c < NUM_CH; c++) begin
            sq[c]   = t_ch_sum'(px[BYTE_W*(NUM_CH-1-c) +: BYTE_W]) *
                      t_ch_sum'(px[BYTE_W*(NUM_CH-1-c) +: BYTE_W]);
            pair[c] = left_sq[c] + sq[c];
        end
        if (col_pos % 2 == 0) begin
            left_sq = sq;
        end else if (row_pos % 2 == 0) begin
            for (int c = 0; c < NUM_CH; c++) pair_sq_mem[idx][c] = pair[c];
        end else begin
            for (int c = 0; c < NUM_CH; c++)
                root[c] = int_root((int'(pair_sq_mem[idx][c]) + int'(pair[c])) >> 2);
            res.color = {ALPHA_OPAQUE, root[0], root[1], root[2]};
            res.eor   = (idx == (w >> 1) - 1);
            res.eoi   = res.eor && ((row_pos >> 1) == (h >> 1) - 1);
            has       = 1'b1;
        end
        if (col_pos + 1 >= w) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
        return has;
    endfunction

    function automatic logic [31:0] rand_pixel();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == REG_SRC_WIDTH) src_w_q = data[CFG_WIDTH_W-1:0];
        else src_h_q = data;
    endtask

    task automatic wait_drained();
        while (src_pixels_q.size() != 0 || i_valid || mip_px_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : drive_pixels
        logic        nxt_valid;
        logic [31:0] nxt_pix;
        t_mip_px     pred;
        nxt_valid = i_valid;
        nxt_pix   = i_pixel_in;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                if (downsample_pixel(i_pixel_in, pred)) mip_px_q.push_back(pred);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && src_pixels_q.size() != 0 &&
                !(gaps_on && $urandom_range(99) < 28)) begin
                nxt_valid = 1'b1;
                nxt_pix   = src_pixels_q.pop_front();
            end
        end
        i_valid    <= nxt_valid;
        i_pixel_in <= nxt_pix;
    end

    always @(posedge i_clk) begin : check_results
        logic    took;
        logic    nxt_stall;
        t_mip_px want;
        took = i_rst_n && o_valid && !i_stall;
        if (took) begin
            if (mip_px_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected transaction, expected none actual %h",
                         $time, o_out_color);
            end else begin
                want = mip_px_q.pop_front();
                if (o_out_color !== want.color) begin
                    mismatches++;
                    $display("%0t: out_color expected %h actual %h",
                             $time, want.color, o_out_color);
                end
                if (o_end_of_row !== want.eor) begin
                    mismatches++;
                    $display("%0t: end_of_row expected %b actual %b",
                             $time, want.eor, o_end_of_row);
                end
                if (o_end_of_image !== want.eoi) begin
                    mismatches++;
                    $display("%0t: end_of_image expected %b actual %b",
                             $time, want.eoi, o_end_of_image);
                end
            end
        end
        if (hold_left != 0) begin
            nxt_stall = 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done && took) begin
            nxt_stall = 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            nxt_stall = gaps_on && ($urandom_range(99) < 28);
        end
        i_stall <= nxt_stall;
    end

    always @(posedge i_clk) begin : watchdog
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL rms_2x2_mipmap_downsample_top");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned w_raw, h_raw, w, h, n, c, r, random_items;
        random_items = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(REG_SRC_WIDTH, 13'd4);
        write_reg(REG_SRC_HEIGHT, 13'd4);
        src_pixels_q = '{32'h00FFFFFF, 32'hFFFFFFFF, 32'h00000000, 32'hFF000000,
                         32'h7FFFFFFF, 32'h00FFFFFF, 32'h00000000, 32'h00000000,
                         32'h00FF0000, 32'h0000FF00, 32'h000000FF, 32'h00800080,
                         32'h00000000, 32'h00000000, 32'h00FFFFFF, 32'h00010101};
        wait_drained();

        // odd width and height: last column and row drop out
        write_reg(REG_SRC_WIDTH, 13'd3);
        write_reg(REG_SRC_HEIGHT, 13'd3);
        src_pixels_q = '{32'h00FF00FF, 32'h0000FF00, 32'h12345678,
                         32'hAA55AA55, 32'h55AA55AA, 32'h00000001,
                         32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF};
        wait_drained();

        while (random_items < RANDOM_PIX) begin
            case ($urandom_range(9))
                0:       w_raw = $urandom_range(0, 1);
                1:       w_raw = 13'h1000 | $urandom_range(2, 12);
                2:       w_raw = $urandom_range(17, 40);
                default: w_raw = $urandom_range(2, 12);
            endcase
            case ($urandom_range(9))
                0:       h_raw = $urandom_range(0, 1);
                1:       h_raw = $urandom_range(13, 24);
                default: h_raw = $urandom_range(2, 10);
            endcase
            // hold the width on an odd row if it would grow past the stored pairs
            if (row_pos % 2 == 1 &&
                clamp_dim(w_raw % 4096, MAX_W) > clamp_dim(src_w_q, MAX_W))
                w_raw = src_w_q;
            write_reg(REG_SRC_WIDTH, w_raw[CFG_DATA_W-1:0]);
            write_reg(REG_SRC_HEIGHT, h_raw[CFG_DATA_W-1:0]);
            w = clamp_dim(src_w_q, MAX_W);
            h = clamp_dim(src_h_q, MAX_H);
            if (w * h <= 150 && $urandom_range(99) < 70)
                n = w * h * $urandom_range(1, 2);
            else
                n = $urandom_range(1, (w * h < 150) ? w * h : 150);
            repeat (n) src_pixels_q.push_back(rand_pixel());
            random_items += n;
            wait_drained();
        end

        // advance to the start of a level
        w = clamp_dim(src_w_q, MAX_W);
        h = clamp_dim(src_h_q, MAX_H);
        c = col_pos;
        r = row_pos;
        n = 0;
        while (c != 0 || r != 0) begin
            if (c + 1 >= w) begin
                c = 0;
                r = (r + 1 >= h) ? 0 : r + 1;
            end else begin
                c = c + 1;
            end
            n++;
        end
        repeat (n) src_pixels_q.push_back(rand_pixel());
        wait_drained();

        // widest and tallest limits, a short run on the first row
        write_reg(REG_SRC_WIDTH, 13'h1FFF);
        write_reg(REG_SRC_HEIGHT, 13'h1FFF);
        repeat (WIDE_PIX) src_pixels_q.push_back(rand_pixel());
        wait_drained();

        // narrow the row, receiver holds off once mid-level
        write_reg(REG_SRC_WIDTH, 13'd16);
        write_reg(REG_SRC_HEIGHT, 13'd4);
        hold_req = 1'b1;
        repeat (HOLD_PIX) src_pixels_q.push_back(rand_pixel());
        wait_drained();

        // no idling on either side
        write_reg(REG_SRC_WIDTH, 13'd8);
        write_reg(REG_SRC_HEIGHT, 13'd8);
        gaps_on = 1'b0;
        repeat (STEADY_PIX) src_pixels_q.push_back(rand_pixel());
        wait_drained();

        if (mismatches == 0) begin
            $display("PASS rms_2x2_mipmap_downsample_top");
        end else begin
            $display("FAIL rms_2x2_mipmap_downsample_top");
        end
        $finish;
    end

endmodule
